### design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define SST_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define SST_ASSERT_IMP(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);

// next-cycle implication
`define SST_ASSERT_NXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

### design/sst_pkg.sv
`timescale 1ns / 1ps

package sst_pkg;

  localparam int OFFSET_BITS = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int OUT_OFF_W   = 16;
  localparam int MAX_RESULTS = 4;

  localparam logic [1:0] KIND_VALUE = 2'd0;
  localparam logic [1:0] KIND_TOKEN = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_ILLEGAL = 3'd1;
  localparam logic [2:0] ERR_DOT     = 3'd2;
  localparam logic [2:0] ERR_BAR     = 3'd3;
  localparam logic [2:0] ERR_AMP     = 3'd4;

  localparam logic [5:0]
    CLS_EOF = 6'd0, CLS_IDENT = 6'd1, CLS_NUMBER = 6'd2, CLS_STRING = 6'd3,
    CLS_EQ_EQ = 6'd4, CLS_ARROW = 6'd5, CLS_EQ = 6'd6, CLS_OR_OR = 6'd7,
    CLS_AND_AND = 6'd8, CLS_NOT_EQ = 6'd9, CLS_NOT = 6'd10, CLS_LT_EQ = 6'd11,
    CLS_LT = 6'd12, CLS_GT_EQ = 6'd13, CLS_GT = 6'd14, CLS_PLUS_EQ = 6'd15,
    CLS_INC = 6'd16, CLS_PLUS = 6'd17, CLS_DEREF = 6'd18, CLS_MINUS_EQ = 6'd19,
    CLS_DEC = 6'd20, CLS_MINUS = 6'd21, CLS_MUL_EQ = 6'd22, CLS_MUL = 6'd23,
    CLS_DIV_EQ = 6'd24, CLS_DIV = 6'd25, CLS_MOD_EQ = 6'd26, CLS_MOD = 6'd27,
    CLS_XOR_EQ = 6'd28, CLS_XOR = 6'd29, CLS_LPAREN = 6'd30, CLS_RPAREN = 6'd31,
    CLS_LBRACE = 6'd32, CLS_RBRACE = 6'd33, CLS_LBRACK = 6'd34, CLS_RBRACK = 6'd35,
    CLS_COMMA = 6'd36, CLS_SEMI = 6'd37;

  typedef struct packed {
    logic [1:0]           kind;
    logic [7:0]           vbyte;
    logic [5:0]           cls;
    logic [OUT_OFF_W-1:0] soff;
    logic [OUT_OFF_W-1:0] eoff;
    logic [2:0]           err;
  } result_t;

  // all results caused by one request, at most four
  typedef struct packed {
    logic [1:0]                   cnt_m1;
    result_t [MAX_RESULTS-1:0]    res;
  } run_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] cls;
  } cls_opt_t;

  function automatic logic is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == " " || c == "\t" || c == "\n" || c == "\r";
  endfunction

  function automatic logic is_op_start(logic [7:0] c);
    return c == "=" || c == "|" || c == "&" || c == "!" || c == "<" || c == ">" ||
           c == "+" || c == "-" || c == "*" || c == "/" || c == "%" || c == "^";
  endfunction

  function automatic cls_opt_t pair_class(logic [7:0] op, logic [7:0] c);
    cls_opt_t r;
    r = '{ok: 1'b0, cls: CLS_EOF};
    case (op)
      "=": if (c == "=") r = '{1'b1, CLS_EQ_EQ};
           else if (c == ">") r = '{1'b1, CLS_ARROW};
      "|": if (c == "|") r = '{1'b1, CLS_OR_OR};
      "&": if (c == "&") r = '{1'b1, CLS_AND_AND};
      "!": if (c == "=") r = '{1'b1, CLS_NOT_EQ};
      "<": if (c == "=") r = '{1'b1, CLS_LT_EQ};
      ">": if (c == "=") r = '{1'b1, CLS_GT_EQ};
      "+": if (c == "=") r = '{1'b1, CLS_PLUS_EQ};
           else if (c == "+") r = '{1'b1, CLS_INC};
      "-": if (c == ">") r = '{1'b1, CLS_DEREF};
           else if (c == "=") r = '{1'b1, CLS_MINUS_EQ};
           else if (c == "-") r = '{1'b1, CLS_DEC};
      "*": if (c == "=") r = '{1'b1, CLS_MUL_EQ};
      "/": if (c == "=") r = '{1'b1, CLS_DIV_EQ};
      "%": if (c == "=") r = '{1'b1, CLS_MOD_EQ};
      "^": if (c == "=") r = '{1'b1, CLS_XOR_EQ};
      default: r = '{ok: 1'b0, cls: CLS_EOF};
    endcase
    return r;
  endfunction

  function automatic cls_opt_t single_class(logic [7:0] op);
    cls_opt_t r;
    r = '{ok: 1'b1, cls: CLS_EOF};
    case (op)
      "=": r.cls = CLS_EQ;
      "!": r.cls = CLS_NOT;
      "<": r.cls = CLS_LT;
      ">": r.cls = CLS_GT;
      "+": r.cls = CLS_PLUS;
      "-": r.cls = CLS_MINUS;
      "*": r.cls = CLS_MUL;
      "/": r.cls = CLS_DIV;
      "%": r.cls = CLS_MOD;
      "^": r.cls = CLS_XOR;
      default: r.ok = 1'b0;
    endcase
    return r;
  endfunction

  function automatic cls_opt_t bracket_class(logic [7:0] c);
    cls_opt_t r;
    r = '{ok: 1'b1, cls: CLS_EOF};
    case (c)
      "(": r.cls = CLS_LPAREN;
      ")": r.cls = CLS_RPAREN;
      "{": r.cls = CLS_LBRACE;
      "}": r.cls = CLS_RBRACE;
      "[": r.cls = CLS_LBRACK;
      "]": r.cls = CLS_RBRACK;
      ",": r.cls = CLS_COMMA;
      ";": r.cls = CLS_SEMI;
      default: r.ok = 1'b0;
    endcase
    return r;
  endfunction

endpackage

### design/sst_front.sv
`timescale 1ns / 1ps

module sst_front #(
  parameter int OFFSET_BITS = sst_pkg::OFFSET_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        char_byte,
  input  logic              byte_valid,
  input  logic              end_of_source,
  input  logic              src_valid,
  output logic              src_ready,
  input  sst_pkg::q_stat_t  q_stat,
  output logic              push,
  output sst_pkg::run_t     push_run
);

  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_IDENT   = 3'd1;
  localparam logic [2:0] MODE_NUMBER  = 3'd2;
  localparam logic [2:0] MODE_STRING  = 3'd3;
  localparam logic [2:0] MODE_ESCAPE  = 3'd4;
  localparam logic [2:0] MODE_OPER    = 3'd5;
  localparam logic [2:0] MODE_COMMENT = 3'd6;
  localparam logic [2:0] MODE_HALT    = 3'd7;

  localparam int OW = OFFSET_BITS;
  localparam int QW = sst_pkg::OUT_OFF_W;

  logic [2:0]    mode, mode_next;
  logic [7:0]    pend, pend_next;
  logic          qsingle, qsingle_next;
  logic          dot, dot_next;
  logic [OW-1:0] tstart, tstart_next;
  logic [OW-1:0] bcount, bcount_next;

  logic [2:0]    n;
  sst_pkg::result_t [sst_pkg::MAX_RESULTS-1:0] res;
  logic          disp;
  logic [OW-1:0] p, pn, pf;
  logic [7:0]    c;
  sst_pkg::cls_opt_t pc, sc, bc;
  logic          accept;

  function automatic logic [OW-1:0] sat_inc(logic [OW-1:0] v);
    return (v == {OW{1'b1}}) ? v : v + 1'b1;
  endfunction

  function automatic logic [QW-1:0] lo16(logic [OW-1:0] v);
    logic [OW+QW-1:0] w;
    w = {{QW{1'b0}}, v};
    return w[QW-1:0];
  endfunction

  function automatic sst_pkg::result_t mk_val(logic [7:0] b, logic [5:0] cls,
                                              logic [OW-1:0] s);
    return '{kind: sst_pkg::KIND_VALUE, vbyte: b, cls: cls, soff: lo16(s),
             eoff: '0, err: sst_pkg::ERR_NONE};
  endfunction

  function automatic sst_pkg::result_t mk_tok(logic [5:0] cls, logic [OW-1:0] s,
                                              logic [OW-1:0] e);
    return '{kind: sst_pkg::KIND_TOKEN, vbyte: 8'h00, cls: cls, soff: lo16(s),
             eoff: lo16(e), err: sst_pkg::ERR_NONE};
  endfunction

  function automatic sst_pkg::result_t mk_err(logic [2:0] code, logic [OW-1:0] s);
    return '{kind: sst_pkg::KIND_ERROR, vbyte: 8'h00, cls: sst_pkg::CLS_EOF,
             soff: lo16(s), eoff: '0, err: code};
  endfunction

  function automatic logic [2:0] lone_code(logic [7:0] op);
    return (op == "|") ? sst_pkg::ERR_BAR :
           (op == "&") ? sst_pkg::ERR_AMP : sst_pkg::ERR_ILLEGAL;
  endfunction

  assign src_ready = !q_stat.full;
  assign accept    = src_valid && src_ready;

  always_comb begin
    mode_next    = mode;
    pend_next    = pend;
    qsingle_next = qsingle;
    dot_next     = dot;
    tstart_next  = tstart;
    c    = char_byte;
    p    = bcount;
    pn   = sat_inc(bcount);
    pf   = byte_valid ? pn : p;
    n    = 3'd0;
    res  = '0;
    disp = 1'b0;
    pc   = sst_pkg::pair_class(pend, c);
    sc   = sst_pkg::single_class(pend);
    bc   = sst_pkg::bracket_class(c);

    if (byte_valid) begin
      unique case (mode)
        MODE_IDLE: disp = 1'b1;
        MODE_IDENT: begin
          if (sst_pkg::is_letter(c) || sst_pkg::is_digit(c) || c == "_") begin
            res[n[1:0]] = mk_val(c, sst_pkg::CLS_IDENT, tstart_next);
            n = n + 3'd1;
          end else begin
            res[n[1:0]] = mk_tok(sst_pkg::CLS_IDENT, tstart_next, p);
            n = n + 3'd1;
            mode_next = MODE_IDLE;
            disp = 1'b1;
          end
        end
        MODE_NUMBER: begin
          if (sst_pkg::is_digit(c)) begin
            res[n[1:0]] = mk_val(c, sst_pkg::CLS_NUMBER, tstart_next);
            n = n + 3'd1;
          end else if (c == "_") begin
            // separator dropped
          end else if (c == ".") begin
            if (dot) begin
              res[n[1:0]] = mk_err(sst_pkg::ERR_DOT, p);
              n = n + 3'd1;
              mode_next = MODE_HALT;
            end else begin
              dot_next = 1'b1;
              res[n[1:0]] = mk_val(c, sst_pkg::CLS_NUMBER, tstart_next);
              n = n + 3'd1;
            end
          end else begin
            res[n[1:0]] = mk_tok(sst_pkg::CLS_NUMBER, tstart_next, p);
            n = n + 3'd1;
            mode_next = MODE_IDLE;
            disp = 1'b1;
          end
        end
        MODE_STRING: begin
          if (c == (qsingle ? 8'("'") : 8'("\""))) begin
            res[n[1:0]] = mk_tok(sst_pkg::CLS_STRING, tstart_next, pn);
            n = n + 3'd1;
            mode_next = MODE_IDLE;
          end else if (c == "\\") begin
            mode_next = MODE_ESCAPE;
          end else begin
            res[n[1:0]] = mk_val(c, sst_pkg::CLS_STRING, tstart_next);
            n = n + 3'd1;
          end
        end
        MODE_ESCAPE: begin
          res[n[1:0]] = mk_val((c == "n") ? 8'h0A : ((c == "t") ? 8'h09 : c),
                               sst_pkg::CLS_STRING, tstart_next);
          n = n + 3'd1;
          mode_next = MODE_STRING;
        end
        MODE_OPER: begin
          if (pend == ">" && c == ">") begin
            mode_next = MODE_COMMENT;
          end else if (pc.ok) begin
            res[n[1:0]] = mk_tok(pc.cls, tstart_next, pn);
            n = n + 3'd1;
            mode_next = MODE_IDLE;
          end else if (sc.ok) begin
            res[n[1:0]] = mk_tok(sc.cls, tstart_next, p);
            n = n + 3'd1;
            mode_next = MODE_IDLE;
            disp = 1'b1;
          end else begin
            res[n[1:0]] = mk_err(lone_code(pend), p);
            n = n + 3'd1;
            mode_next = MODE_HALT;
          end
        end
        MODE_COMMENT: if (c == "\n") mode_next = MODE_IDLE;
        MODE_HALT: ;
        default: ;
      endcase

      // a byte seen in idle mode, or one that ended an identifier, number or single operator, opens the next token
      if (disp) begin
        if (sst_pkg::is_space(c)) begin
          // skipped
        end else if (sst_pkg::is_letter(c) || c == "_") begin
          mode_next   = MODE_IDENT;
          tstart_next = p;
          res[n[1:0]] = mk_val(c, sst_pkg::CLS_IDENT, p);
          n = n + 3'd1;
        end else if (sst_pkg::is_digit(c)) begin
          mode_next   = MODE_NUMBER;
          dot_next    = 1'b0;
          tstart_next = p;
          res[n[1:0]] = mk_val(c, sst_pkg::CLS_NUMBER, p);
          n = n + 3'd1;
        end else if (c == "\"" || c == "'") begin
          mode_next    = MODE_STRING;
          qsingle_next = (c == "'");
          tstart_next  = p;
        end else if (sst_pkg::is_op_start(c)) begin
          mode_next   = MODE_OPER;
          pend_next   = c;
          tstart_next = p;
        end else if (bc.ok) begin
          res[n[1:0]] = mk_tok(bc.cls, p, pn);
          n = n + 3'd1;
        end else begin
          res[n[1:0]] = mk_err(sst_pkg::ERR_ILLEGAL, p);
          n = n + 3'd1;
          mode_next = MODE_HALT;
        end
      end
    end

    if (end_of_source) begin
      case (mode_next)
        MODE_IDENT: begin
          res[n[1:0]] = mk_tok(sst_pkg::CLS_IDENT, tstart_next, pf);
          n = n + 3'd1;
        end
        MODE_NUMBER: begin
          res[n[1:0]] = mk_tok(sst_pkg::CLS_NUMBER, tstart_next, pf);
          n = n + 3'd1;
        end
        MODE_STRING, MODE_ESCAPE: begin
          res[n[1:0]] = mk_tok(sst_pkg::CLS_STRING, tstart_next, pf);
          n = n + 3'd1;
        end
        MODE_OPER: begin
          // pend_next is the operator that waits here
          if (sst_pkg::single_class(pend_next).ok) begin
            res[n[1:0]] = mk_tok(sst_pkg::single_class(pend_next).cls, tstart_next, pf);
            n = n + 3'd1;
            mode_next = MODE_IDLE;
          end else begin
            res[n[1:0]] = mk_err(lone_code(pend_next), pf);
            n = n + 3'd1;
            mode_next = MODE_HALT;
          end
        end
        default: ;
      endcase
      if (mode_next != MODE_HALT) begin
        res[n[1:0]] = mk_tok(sst_pkg::CLS_EOF, pf, pf);
        n = n + 3'd1;
      end
    end
  end

  assign bcount_next = byte_valid ? pn : p;

  assign push            = accept && (n != 3'd0);
  assign push_run.cnt_m1 = 2'(n - 3'd1);
  assign push_run.res    = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_IDLE;
      pend    <= 8'h00;
      qsingle <= 1'b0;
      dot     <= 1'b0;
      tstart  <= '0;
      bcount  <= '0;
    end else if (accept) begin
      if (end_of_source) begin
        // a new source starts after the final request
        mode    <= MODE_IDLE;
        pend    <= 8'h00;
        qsingle <= 1'b0;
        dot     <= 1'b0;
        tstart  <= '0;
        bcount  <= '0;
      end else begin
        mode    <= mode_next;
        pend    <= pend_next;
        qsingle <= qsingle_next;
        dot     <= dot_next;
        tstart  <= tstart_next;
        bcount  <= bcount_next;
      end
    end
  end

`include "assert_macros.svh"

  `SST_ASSERT_IMP(a_halt_silent, accept && mode == MODE_HALT, n == 3'd0, "halted lexer produced a result")
  `SST_ASSERT_IMP(a_push_space, push, !q_stat.full, "run pushed into a full queue")

endmodule

### design/sst_fifo.sv
`timescale 1ns / 1ps

module sst_fifo #(
  parameter int WIDTH = $bits(sst_pkg::run_t),
  parameter int DEPTH = sst_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [WIDTH-1:0]  din,
  input  logic              pop,
  output logic [WIDTH-1:0]  dout,
  output sst_pkg::q_stat_t  stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr, rptr;
  logic [CW-1:0]    count;

  function automatic logic [AW-1:0] wrap_inc(logic [AW-1:0] v);
    return (v == AW'(DEPTH - 1)) ? '0 : v + 1'b1;
  endfunction

  assign stat.full  = (count == CW'(DEPTH));
  assign stat.empty = (count == '0);
  assign dout       = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wrap_inc(wptr);
      if (pop)  rptr <= wrap_inc(rptr);
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

`include "assert_macros.svh"

  `SST_ASSERT_IMP(a_no_underflow, pop, !stat.empty, "pop from an empty queue")

endmodule

### design/sst_back.sv
`timescale 1ns / 1ps

module sst_back (
  input  logic              clk,
  input  logic              rst,
  input  sst_pkg::q_stat_t  q_stat,
  input  sst_pkg::run_t     q_run,
  output logic              pop,
  output logic              res_valid,
  input  logic              res_ready,
  output logic [1:0]        result_kind,
  output logic [7:0]        value_byte,
  output logic [5:0]        token_class,
  output logic [15:0]       start_offset,
  output logic [15:0]       end_offset,
  output logic [2:0]        error_code,
  output logic              last_of_run
);

  logic          busy;
  logic [1:0]    idx;
  sst_pkg::run_t cur;
  sst_pkg::result_t sel;
  logic          done;

  assign sel       = cur.res[idx];
  assign res_valid = busy;
  assign last_of_run = (idx == cur.cnt_m1);
  assign done      = busy && res_ready && last_of_run;
  assign pop       = !q_stat.empty && (!busy || done);

  assign result_kind  = sel.kind;
  assign value_byte   = sel.vbyte;
  assign token_class  = sel.cls;
  assign start_offset = sel.soff;
  assign end_offset   = sel.eoff;
  assign error_code   = sel.err;

  always_ff @(posedge clk) begin
    if (pop) cur <= q_run;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 2'd0;
    end else if (pop) begin
      busy <= 1'b1;
      idx  <= 2'd0;
    end else if (done) begin
      busy <= 1'b0;
    end else if (busy && res_ready) begin
      idx <= idx + 2'd1;
    end
  end

`include "assert_macros.svh"

  `SST_ASSERT_NXT(a_hold_stall, busy && !res_ready, busy && $stable(idx), "stalled request moved on")
  `SST_ASSERT(a_idx_in_run, !busy || idx <= cur.cnt_m1, "result index past end of run")

endmodule

### design/script_source_tokenizer.sv
`timescale 1ns / 1ps
// channel | handshake            | payload
// source  | src_valid, src_ready | char_byte, byte_valid, end_of_source
// result  | res_valid, res_ready | result_kind, value_byte, token_class, start_offset,
//         |                      | end_offset, error_code, last_of_run
//
// one source byte is taken each cycle while the run queue has room; the next lexer
// state is computed combinationally from the current state and byte
// each request gives zero to four results, sent one a cycle from the run queue
// while res_ready is high
// reset is synchronous and clears lexer state, queue pointers and result valid
// a stalled result side fills the queue, then src_ready drops

module script_source_tokenizer #(
  parameter int OFFSET_BITS = sst_pkg::OFFSET_BITS,
  parameter int QUEUE_DEPTH = sst_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        src_valid,
  output logic        src_ready,
  input  logic [7:0]  char_byte,
  input  logic        byte_valid,
  input  logic        end_of_source,
  output logic        res_valid,
  input  logic        res_ready,
  output logic [1:0]  result_kind,
  output logic [7:0]  value_byte,
  output logic [5:0]  token_class,
  output logic [15:0] start_offset,
  output logic [15:0] end_offset,
  output logic [2:0]  error_code,
  output logic        last_of_run
);

  localparam int RW = $bits(sst_pkg::run_t);

  sst_pkg::q_stat_t q_stat;
  sst_pkg::run_t    push_run, q_run;
  logic             push, pop;
  logic [RW-1:0]    q_dout;

  sst_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
    .clk           (clk),
    .rst           (rst),
    .char_byte     (char_byte),
    .byte_valid    (byte_valid),
    .end_of_source (end_of_source),
    .src_valid     (src_valid),
    .src_ready     (src_ready),
    .q_stat        (q_stat),
    .push          (push),
    .push_run      (push_run)
  );

  sst_fifo #(.WIDTH(RW), .DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (push_run),
    .pop  (pop),
    .dout (q_dout),
    .stat (q_stat)
  );

  assign q_run = q_dout;

  sst_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_stat       (q_stat),
    .q_run        (q_run),
    .pop          (pop),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .result_kind  (result_kind),
    .value_byte   (value_byte),
    .token_class  (token_class),
    .start_offset (start_offset),
    .end_offset   (end_offset),
    .error_code   (error_code),
    .last_of_run  (last_of_run)
  );

endmodule
